// ----- hw/rtl/rhc_pkg.sv -----
// shared types and constants for the rgb to hsv converter
package rhc_pkg;

  localparam int ChanW = 8;
  localparam int HueW = 15;
  localparam int SatW = 16;
  localparam int QuoW = 16;
  localparam int DivW = ChanW + QuoW;
  localparam int StepsPerStage = 2;
  localparam int DivStages = QuoW / StepsPerStage;
  localparam int HuePerSector = 3840;

  // one long division: remainder in the upper bits, quotient shifts in below
  typedef struct packed {
    logic [DivW-1:0]  acc;
    logic [ChanW-1:0] den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        sat;
    div_lane_t        hue;
    logic [ChanW-1:0] value_level;
    logic             achromatic;
  } div_item_t;

endpackage

// ----- hw/rtl/rhc_front.sv -----
// max/min, hue sector and dividend setup, two register stages
module rhc_front import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             out_valid,
  input  logic             out_ready,
  output div_item_t        out_item
);

  localparam int SumW = ChanW + 4;
  localparam int HueSumW = SumW - 1;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  logic                    a_valid;
  logic [ChanW-1:0]        a_value;
  logic [ChanW-1:0]        a_delta;
  logic                    a_achro;
  sector_t                 a_sector;
  logic signed [ChanW:0]   a_diff;
  logic                    a_ready;
  logic                    b_ready;

  sector_t                 sector_c;
  logic [ChanW-1:0]        max_c;
  logic [ChanW-1:0]        min_c;
  logic signed [ChanW:0]   diff_c;

  logic [SumW-1:0]         base_c;
  logic [SumW-1:0]         sum_c;
  logic [SumW-1:0]         six_d_c;
  logic [SumW-1:0]         wrap_c;
  logic [HueSumW-1:0]      pos_c;
  div_item_t               item_c;

  assign b_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    if (red >= green && red >= blue) begin
      sector_c = SEC_RED;
    end else if (green >= blue) begin
      sector_c = SEC_GREEN;
    end else begin
      sector_c = SEC_BLUE;
    end
    min_c = (red < green) ? red : green;
    min_c = (blue < min_c) ? blue : min_c;
    case (sector_c)
      SEC_RED: begin
        max_c  = red;
        diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
      end
      SEC_GREEN: begin
        max_c  = green;
        diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
      end
      default: begin
        max_c  = blue;
        diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_value  <= max_c;
      a_delta  <= max_c - min_c;
      a_achro  <= (max_c == min_c);
      a_sector <= sector_c;
      a_diff   <= diff_c;
    end
  end

  // hue numerator in sector units, wrapped to a full turn of six sectors
  always_comb begin
    case (a_sector)
      SEC_RED:   base_c = '0;
      SEC_GREEN: base_c = SumW'({a_delta, 1'b0});
      default:   base_c = SumW'({a_delta, 2'b0});
    endcase
    six_d_c = SumW'({a_delta, 2'b0}) + SumW'({a_delta, 1'b0});
    sum_c   = base_c + {{(SumW-ChanW-1){a_diff[ChanW]}}, a_diff};
    wrap_c  = sum_c[SumW-1] ? sum_c + six_d_c : sum_c;
    pos_c   = wrap_c[HueSumW-1:0];

    item_c.hue.acc = DivW'(pos_c) * DivW'(HuePerSector) + DivW'(a_delta >> 1);
    item_c.hue.den = a_delta;
    item_c.sat.acc = {a_delta, QuoW'(0)} - DivW'(a_delta);
    item_c.sat.den = a_value;
    item_c.value_level = a_value;
    item_c.achromatic  = a_achro;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      out_item <= item_c;
    end
  end

endmodule

// ----- hw/rtl/rhc_div_stage.sv -----
// one divider stage: StepsPerStage restoring steps on the hue and saturation lanes
module rhc_div_stage import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  function automatic div_lane_t div_step(div_lane_t lane);
    logic [ChanW:0] part;
    logic [ChanW:0] rest;
    div_lane_t      res;
    part = lane.acc[DivW-1 -: ChanW+1];
    rest = part - {1'b0, lane.den};
    res.den = lane.den;
    if (part >= {1'b0, lane.den}) begin
      res.acc = {rest[ChanW-1:0], lane.acc[DivW-ChanW-2:0], 1'b1};
    end else begin
      res.acc = {part[ChanW-1:0], lane.acc[DivW-ChanW-2:0], 1'b0};
    end
    return res;
  endfunction

  div_item_t item_c;

  always_comb begin
    item_c = in_item;
    for (int i = 0; i < StepsPerStage; i++) begin
      item_c.sat = div_step(item_c.sat);
      item_c.hue = div_step(item_c.hue);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= item_c;
    end
  end

endmodule

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// rgb to hsv converter top level: front stages, divider pipeline, output register
//
//   channel | signals                                   | request
//   pixel   | pixel_valid pixel_ready red green blue    | one rgb pixel
//   hsv     | hsv_valid hsv_ready hue saturation        | one hsv result
//           | value_level achromatic                    |
//
// one pixel per clock sustained while hsv_ready stays high
// pipeline: the divider gives 16 quotient bits, two per stage, 8 stages,
// plus two front stages and the output register
// reset clears every stage valid bit; no payload is reset
// each stage holds while its successor is full and stalled, bubbles collapse
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             hsv_valid,
  input  logic             hsv_ready,
  output logic [HueW-1:0]  hue,
  output logic [SatW-1:0]  saturation,
  output logic [ChanW-1:0] value_level,
  output logic             achromatic
);

  div_item_t item  [0:DivStages];
  logic      valid [0:DivStages];
  logic      ready [0:DivStages];
  div_item_t last;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_ready  (pixel_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_item  (item[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rhc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[s]),
      .in_ready  (ready[s]),
      .in_item   (item[s]),
      .out_valid (valid[s+1]),
      .out_ready (ready[s+1]),
      .out_item  (item[s+1])
    );
  end

  assign last = item[DivStages];
  assign ready[DivStages] = !hsv_valid || hsv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (ready[DivStages]) begin
      hsv_valid <= valid[DivStages];
    end
    if (ready[DivStages] && valid[DivStages]) begin
      value_level <= last.value_level;
      achromatic  <= last.achromatic;
      hue         <= last.achromatic ? '0 : last.hue.acc[HueW-1:0];
      saturation  <= last.achromatic ? '0 : last.sat.acc[SatW-1:0];
    end
  end

endmodule

// ----- hw/rtl/rhc_checker.sv -----
// port level checks for the rgb to hsv converter, bound to the top level
module rhc_checker import rhc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pixel_ready,
  input logic             hsv_valid,
  input logic             hsv_ready,
  input logic [HueW-1:0]  hue,
  input logic [SatW-1:0]  saturation,
  input logic [ChanW-1:0] value_level,
  input logic             achromatic
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !hsv_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid &&
      $stable(hue) && $stable(saturation) &&
      $stable(value_level) && $stable(achromatic))
    else $error("stalled result changed");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && achromatic |-> hue == '0 && saturation == '0)
    else $error("achromatic result with hue or saturation");

  a_color_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !achromatic |->
      hue < HueW'(6 * HuePerSector) && saturation != '0 && value_level != '0)
    else $error("chromatic result out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !hsv_valid |-> pixel_ready)
    else $error("request refused while output empty");

endmodule

bind rgb_to_hsv_converter rhc_checker u_checker (.*);

// ----- test/tb_top.sv -----
// testbench for the rgb to hsv converter: directed, random and backpressure runs
module tb_top import rhc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HueFullTurn = 6 * HuePerSector;
  localparam int SatScale = 65535;
  localparam int CycleLimit = 300000;
  localparam int MaxIdle = 11;
  localparam int TailCycles = 30;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] value_level;
    logic             achromatic;
  } hsv_t;

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             hsv_valid;
  logic             hsv_ready;
  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;
  logic [ChanW-1:0] value_level;
  logic             achromatic;

  hsv_t expected_hsv[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   max_pixel_gap = MaxIdle;
  int   max_hsv_stall = MaxIdle;
  int   hold_cycles = 0;

  rgb_to_hsv_converter u_top (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hue         (hue),
    .saturation  (saturation),
    .value_level (value_level),
    .achromatic  (achromatic)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic hsv_t predict_hsv(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                       logic [ChanW-1:0] b);
    hsv_t res;
    int mx;
    int mn;
    int delta;
    int sector;
    int diff;
    int num;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    res.hue = '0;
    res.saturation = '0;
    res.value_level = mx[ChanW-1:0];
    res.achromatic = 1'b1;
    if (mx != mn) begin
      delta = mx - mn;
      res.saturation = SatW'((delta * SatScale) / mx);
      res.achromatic = 1'b0;
      // red wins ties, then green
      if (r == mx) begin
        sector = 0;
        diff = int'(g) - int'(b);
      end else if (g == mx) begin
        sector = 2;
        diff = int'(b) - int'(r);
      end else begin
        sector = 4;
        diff = int'(r) - int'(g);
      end
      num = HuePerSector * (sector * delta + diff);
      if (num < 0) num += HueFullTurn * delta;
      res.hue = HueW'((2 * num + delta) / (2 * delta));
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b);
    int gap;
    gap = $urandom_range(0, max_pixel_gap);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!pixel_ready);
    expected_hsv = {expected_hsv, predict_hsv(r, g, b)};
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (expected_hsv.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, optional long hold, compare against oldest request
  initial begin : hsv_sink
    int stall;
    hsv_t want;
    hsv_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        hsv_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = $urandom_range(0, max_hsv_stall);
      if (stall > 0) begin
        hsv_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsv_ready <= 1'b1;
      do @(posedge clk); while (!(hsv_valid && hsv_ready));
      if (expected_hsv.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_hsv.pop_front();
        if (hue !== want.hue)
          report_mismatch($sformatf("hue got %0d expected %0d", hue, want.hue));
        if (saturation !== want.saturation)
          report_mismatch($sformatf("saturation got %0d expected %0d",
                                    saturation, want.saturation));
        if (value_level !== want.value_level)
          report_mismatch($sformatf("value_level got %0d expected %0d",
                                    value_level, want.value_level));
        if (achromatic !== want.achromatic)
          report_mismatch($sformatf("achromatic got %0b expected %0b",
                                    achromatic, want.achromatic));
      end
    end
  end

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd3, 8'd0, 8'd2);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hFF);
    send_pixel(8'd200, 8'd100, 8'd150);
    wait_drained();
  endtask

  task automatic test_random_uniform(int count);
    repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // grays, ties for the maximum, near-gray pixels and pixels with blue as the maximum
  task automatic test_corner_mix(int count);
    logic [ChanW-1:0] a;
    logic [ChanW-1:0] c;
    logic [ChanW-1:0] d;
    repeat (count) begin
      a = 8'($urandom);
      c = 8'($urandom_range(0, a));
      d = 8'($urandom_range(0, a));
      case ($urandom_range(0, 5))
        0: send_pixel(a, a, a);
        1: send_pixel(a, a, c);
        2: send_pixel(a, c, a);
        3: send_pixel(c, a, a);
        4: send_pixel(a, 8'(a - $urandom_range(0, 2)), 8'(a - $urandom_range(0, 2)));
        default: send_pixel(c, d, a);
      endcase
    end
  endtask

  task automatic test_backpressure(int count);
    max_pixel_gap = 0;
    hold_cycles = 300;
    test_random_uniform(count);
    max_pixel_gap = MaxIdle;
    wait_drained();
  endtask

  task automatic test_burst(int count);
    max_pixel_gap = 0;
    max_hsv_stall = 0;
    test_random_uniform(count);
    max_pixel_gap = MaxIdle;
    max_hsv_stall = MaxIdle;
  endtask

  task automatic test_drain_pause(int count);
    test_corner_mix(count);
    wait_drained();
    test_random_uniform(count);
  endtask

  initial begin
    rst <= 1'b1;
    pixel_valid <= 1'b0;
    red <= '0;
    green <= '0;
    blue <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_uniform(500);
    test_corner_mix(300);
    test_burst(150);
    test_backpressure(120);
    test_drain_pause(80);
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
